// ===== src/swbi_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swbi_pkg
// Shared constants and types for the stack with bottom increment: sizes,
// operation codes and the control bundle broadcast along the cell row.
// ----------------------------------------------------------------------------
package swbi_pkg;

    localparam int DEPTH       = 1024;
    localparam int DATA_W      = 32;
    localparam int CELL_IDX_W  = $clog2(DEPTH);
    localparam int FILL_W      = $clog2(DEPTH + 1);
    localparam int CFG_W       = 11;
    localparam int VAL_IN_W    = 16;
    localparam int CNT_IN_W    = 11;
    localparam int AMT_IN_W    = 16;
    localparam int OP_W        = 2;
    localparam int IN_DATA_W   = 48;
    localparam int APB_ADDR_W  = 3;
    localparam int APB_DATA_W  = 32;

    localparam logic [CFG_W-1:0] CAP_RESET = CFG_W'(1024);

    // Register index of max_entries, taken from paddr[2].
    localparam logic REG_MAX_ENTRIES = 1'b0;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH = 2'd0,
        OP_POP  = 2'd1,
        OP_INC  = 2'd2
    } opcode_t;

    typedef struct packed {
        logic                  push;
        logic                  pop;
        logic                  inc;
        logic [CELL_IDX_W-1:0] target;
        logic [DATA_W-1:0]     amount;
    } cell_ctrl_t;

endpackage

// ===== src/swbi_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swbi_cell
// One stack slot: a value and a pending delta. It shifts towards the bottom
// on a push, towards the top on a pop, and adds the increment when it is the
// addressed slot.
// ----------------------------------------------------------------------------
module swbi_cell (
    input  logic                            aclk,
    input  swbi_pkg::cell_ctrl_t            ctrl,
    input  logic [swbi_pkg::CELL_IDX_W-1:0] cell_index,
    input  logic [swbi_pkg::DATA_W-1:0]     above_value,
    input  logic [swbi_pkg::DATA_W-1:0]     above_delta,
    input  logic [swbi_pkg::DATA_W-1:0]     below_value,
    input  logic [swbi_pkg::DATA_W-1:0]     below_delta,
    input  logic [swbi_pkg::DATA_W-1:0]     pop_carry,
    output logic [swbi_pkg::DATA_W-1:0]     value_q,
    output logic [swbi_pkg::DATA_W-1:0]     delta_q
);

    logic [swbi_pkg::DATA_W-1:0] value_reg;
    logic [swbi_pkg::DATA_W-1:0] delta_reg;
    logic                        hit;

    assign hit = ctrl.inc && (ctrl.target == cell_index);

    always_ff @(posedge aclk) begin
        if (ctrl.push) begin
            value_reg <= above_value;
            delta_reg <= above_delta;
        end else if (ctrl.pop) begin
            // The popped entry's delta is owed to the new top as well.
            value_reg <= below_value;
            delta_reg <= below_delta + pop_carry;
        end else if (hit) begin
            delta_reg <= delta_reg + ctrl.amount;
        end
    end

    assign value_q = value_reg;
    assign delta_q = delta_reg;

endmodule

// ===== src/swbi_cell_row.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swbi_cell_row
// The row of stack cells. Cell 0 is the top of the stack; each cell hands
// its contents to a neighbour when the stack moves.
// ----------------------------------------------------------------------------
module swbi_cell_row (
    input  logic                        aclk,
    input  swbi_pkg::cell_ctrl_t        ctrl,
    input  logic [swbi_pkg::DATA_W-1:0] push_word,
    output logic [swbi_pkg::DATA_W-1:0] top_value,
    output logic [swbi_pkg::DATA_W-1:0] top_delta
);

    logic [swbi_pkg::DATA_W-1:0] value_w [swbi_pkg::DEPTH];
    logic [swbi_pkg::DATA_W-1:0] delta_w [swbi_pkg::DEPTH];

    genvar i;
    generate
        for (i = 0; i < swbi_pkg::DEPTH; i++) begin : g_cell
            logic [swbi_pkg::DATA_W-1:0] up_value;
            logic [swbi_pkg::DATA_W-1:0] up_delta;
            logic [swbi_pkg::DATA_W-1:0] down_value;
            logic [swbi_pkg::DATA_W-1:0] down_delta;
            logic [swbi_pkg::DATA_W-1:0] carry;

            if (i == 0) begin : g_top
                assign up_value = push_word;
                assign up_delta = '0;
                assign carry    = delta_w[0];
            end else begin : g_mid
                assign up_value = value_w[i-1];
                assign up_delta = delta_w[i-1];
                assign carry    = '0;
            end

            if (i == swbi_pkg::DEPTH - 1) begin : g_last
                assign down_value = '0;
                assign down_delta = '0;
            end else begin : g_inner
                assign down_value = value_w[i+1];
                assign down_delta = delta_w[i+1];
            end

            swbi_cell u_cell (
                .aclk        (aclk),
                .ctrl        (ctrl),
                .cell_index  (swbi_pkg::CELL_IDX_W'(i)),
                .above_value (up_value),
                .above_delta (up_delta),
                .below_value (down_value),
                .below_delta (down_delta),
                .pop_carry   (carry),
                .value_q     (value_w[i]),
                .delta_q     (delta_w[i])
            );
        end
    endgenerate

    assign top_value = value_w[0];
    assign top_delta = delta_w[0];

endmodule

// ===== src/stack_with_bottom_increment.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stack_with_bottom_increment
// Bounded LIFO of 32-bit words held in a row of shifting cells, with a
// constant-time increment of the bottom k entries through pending deltas.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake          Contents
//  s_*      in         s_tvalid/s_tready  operation item (push, pop, increment)
//  m_*      out        m_tvalid/m_tready  pop result, one per pop item
//  APB      in/out     psel/penable       max_entries at byte address 0
//
// One item is taken per cycle; every operation completes in the cycle it is
// accepted, as each cell shifts or updates in parallel with its neighbours.
// A pop result appears in the output register on the following cycle.
// s_tready is low only while a result waits in that register and m_tready
// is low. Reset empties the stack and sets max_entries to 1024; cell
// contents are not cleared, since only pushed entries are ever read.
// ----------------------------------------------------------------------------
module stack_with_bottom_increment (
    input  logic                            aclk,
    input  logic                            aresetn,
    // s_tdata: push_value [15:0], inc_count [26:16], inc_amount [42:27]
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [swbi_pkg::IN_DATA_W-1:0]  s_tdata,
    // s_tuser: opcode [1:0]
    input  logic [swbi_pkg::OP_W-1:0]       s_tuser,
    // m_tdata: popped_value [31:0]
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [swbi_pkg::DATA_W-1:0]     m_tdata,
    // m_tuser: was_empty [0]
    output logic                            m_tuser,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [swbi_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [swbi_pkg::APB_DATA_W-1:0] pwdata,
    output logic [swbi_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready
);

    logic [swbi_pkg::CFG_W-1:0]    max_entries_reg;
    logic [swbi_pkg::FILL_W-1:0]   fill_reg;
    logic [swbi_pkg::FILL_W-1:0]   fill_next;
    logic                          out_valid_reg;
    logic [swbi_pkg::DATA_W-1:0]   out_data_reg;
    logic                          out_empty_reg;

    logic                          accept;
    logic [swbi_pkg::VAL_IN_W-1:0] push_value;
    logic [swbi_pkg::CNT_IN_W-1:0] inc_count;
    logic [swbi_pkg::AMT_IN_W-1:0] inc_amount;
    logic [swbi_pkg::FILL_W-1:0]   capacity;
    logic [swbi_pkg::FILL_W-1:0]   count_clip;
    logic [swbi_pkg::FILL_W-1:0]   target_full;
    logic                          is_empty;
    logic                          is_pop;
    swbi_pkg::cell_ctrl_t          ctrl;
    logic [swbi_pkg::DATA_W-1:0]   top_value;
    logic [swbi_pkg::DATA_W-1:0]   top_delta;
    logic                          cfg_write;

    assign push_value = s_tdata[15:0];
    assign inc_count  = s_tdata[26:16];
    assign inc_amount = s_tdata[42:27];

    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    assign capacity = (swbi_pkg::FILL_W'(max_entries_reg) > swbi_pkg::FILL_W'(swbi_pkg::DEPTH))
                    ? swbi_pkg::FILL_W'(swbi_pkg::DEPTH)
                    : swbi_pkg::FILL_W'(max_entries_reg);

    assign is_empty    = (fill_reg == '0);
    assign count_clip  = (swbi_pkg::FILL_W'(inc_count) > fill_reg)
                       ? fill_reg : swbi_pkg::FILL_W'(inc_count);
    // Top of stack is cell 0, so bottom entry k-1 sits at cell fill-k.
    assign target_full = fill_reg - count_clip;

    always_comb begin
        ctrl        = '0;
        ctrl.target = target_full[swbi_pkg::CELL_IDX_W-1:0];
        ctrl.amount = {{(swbi_pkg::DATA_W - swbi_pkg::AMT_IN_W){1'b0}}, inc_amount};
        fill_next   = fill_reg;
        is_pop      = 1'b0;
        case (swbi_pkg::opcode_t'(s_tuser))
            swbi_pkg::OP_PUSH: begin
                if (accept && (fill_reg < capacity)) begin
                    ctrl.push = 1'b1;
                    fill_next = fill_reg + 1'b1;
                end
            end
            swbi_pkg::OP_POP: begin
                is_pop = accept;
                if (accept && !is_empty) begin
                    ctrl.pop  = 1'b1;
                    fill_next = fill_reg - 1'b1;
                end
            end
            swbi_pkg::OP_INC: begin
                ctrl.inc = accept && !is_empty && (inc_count != '0) && (inc_amount != '0);
            end
            default: begin
            end
        endcase
    end

    swbi_cell_row u_row (
        .aclk      (aclk),
        .ctrl      (ctrl),
        .push_word ({{(swbi_pkg::DATA_W - swbi_pkg::VAL_IN_W){1'b0}}, push_value}),
        .top_value (top_value),
        .top_delta (top_delta)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            fill_reg <= fill_next;
            if (is_pop) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (is_pop) begin
            out_data_reg  <= is_empty ? '0 : (top_value + top_delta);
            out_empty_reg <= is_empty;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_empty_reg;

    // Configuration port: the register index is paddr[2].
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr[2] == swbi_pkg::REG_MAX_ENTRIES);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_entries_reg <= swbi_pkg::CAP_RESET;
        end else if (cfg_write) begin
            max_entries_reg <= pwdata[swbi_pkg::CFG_W-1:0];
        end
    end

    assign prdata = (paddr[2] == swbi_pkg::REG_MAX_ENTRIES)
                  ? {{(swbi_pkg::APB_DATA_W - swbi_pkg::CFG_W){1'b0}}, max_entries_reg}
                  : '0;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= swbi_pkg::FILL_W'(swbi_pkg::DEPTH))
        else $error("fill level beyond stack depth");

    a_pop_result: assert property (@(posedge aclk) disable iff (!aresetn)
        is_pop |=> m_tvalid)
        else $error("accepted pop gave no result");

    a_full_push: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && (s_tuser == swbi_pkg::OP_PUSH) && (fill_reg >= capacity))
        |=> $stable(fill_reg))
        else $error("push on a full stack changed the fill level");

    a_empty_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> (m_tdata == '0))
        else $error("empty pop result carries a non-zero value");

endmodule
